// ===== hdl/spi_rgb_led_mux_controller_macros.svh =====
// Assertion macros for the SPI RGB LED multiplexer controller.
// Included by srlmc_back, which carries concurrent checks; no other dependencies.
`ifndef SPI_RGB_LED_MUX_CONTROLLER_MACROS_SVH
`define SPI_RGB_LED_MUX_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRLMC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SRLMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== hdl/srlmc_pkg.sv =====
// Shared types, codes and constants of the SPI RGB LED multiplexer controller.
// No dependencies; used by every module of the block except srlmc_fifo.
package srlmc_pkg;

	localparam int NUM_LEDS_DEF            = 8;
	localparam int NUM_SENSOR_CHANNELS_DEF = 4;
	localparam int QUEUE_DEPTH_DEF         = 2;

	// Input opcodes
	localparam logic [1:0] OP_SPI    = 2'd0;
	localparam logic [1:0] OP_TICK   = 2'd1;
	localparam logic [1:0] OP_SENSOR = 2'd2;

	// SPI byte decoding
	localparam logic [3:0] NIB_READ   = 4'h0;
	localparam logic [3:0] NIB_SELECT = 4'h1;
	localparam logic [7:0] CMD_CAL    = 8'h0e;
	localparam logic [7:0] CMD_STORE  = 8'h0f;
	localparam logic [7:0] CMD_FF     = 8'hff;
	localparam int         LOAD_BIT   = 3;

	localparam logic [1:0] CAL_NONE  = 2'd0;
	localparam logic [1:0] CAL_ONLY  = 2'd1;
	localparam logic [1:0] CAL_STORE = 2'd2;

	localparam logic [7:0] SCAN_PERIOD_RESET = 8'h50;

	typedef enum logic [1:0] {
		K_SPI    = 2'd0,
		K_TICK   = 2'd1,
		K_SENSOR = 2'd2,
		K_NOP    = 2'd3
	} cmd_kind_t;

	typedef enum logic [2:0] {
		SPI_NONE  = 3'd0,
		SPI_READ  = 3'd1,
		SPI_CAL   = 3'd2,
		SPI_STORE = 3'd3,
		SPI_LOAD  = 3'd4,
		SPI_CLEAR = 3'd5,
		SPI_ZERO  = 3'd6
	} spi_class_t;

	typedef enum logic [3:0] {
		PH_IDLE  = 4'b0001,
		PH_RED   = 4'b0010,
		PH_GREEN = 4'b0100,
		PH_BLUE  = 4'b1000
	} load_phase_t;

	typedef struct packed {
		cmd_kind_t  kind;
		spi_class_t spi_class;
		logic       is_ff;
		logic [7:0] data;
		logic [1:0] channel;
		logic [7:0] value;
	} cmd_t;

	typedef struct packed {
		logic       reply_valid;
		logic [7:0] reply_byte;
		logic [1:0] calibrate_request;
		logic       scan_valid;
		logic [2:0] led_select;
		logic [7:0] red_duty;
		logic [7:0] green_duty;
		logic [7:0] blue_duty;
		logic       red_on;
		logic       green_on;
		logic       blue_on;
	} res_t;

	// Start pattern: red, green, blue, yellow, magenta, cyan, then off.
	function automatic logic [23:0] start_colour(input int idx);
		logic [23:0] c;
		case (idx)
			0: c = 24'hff0000;
			1: c = 24'h00ff00;
			2: c = 24'h0000ff;
			3: c = 24'hffff00;
			4: c = 24'hff00ff;
			5: c = 24'h00ffff;
			default: c = 24'h000000;
		endcase
		return c;
	endfunction

endpackage

// ===== hdl/spi_rgb_led_mux_controller.sv =====
// Top level of the SPI RGB LED multiplexer controller.
// Depends on srlmc_pkg, srlmc_front, srlmc_fifo and srlmc_back.

// The block takes one item per clock unless full is high and gives back exactly one
// result item for each, in order. An item is an SPI byte (sensor read-back, calibrate
// request, LED select and three-byte 5-bit colour load, or a zero reply), a scan tick,
// or a sensor update. The front classifies the item into the command queue at the edge
// it is accepted; the back executes it once the result queue has room and writes the
// result into the result queue, whose head drives the output ports. Sustained rate is
// one item per cycle while pop is high, set by the back end's combinational execute
// step; when pop is held low the result queue and then the command queue fill and full
// rises. Colour, sensor and scan state come out of reset at once, so no clearing pass
// is needed. Write scan_period via cfg_we/cfg_wdata only while no item is in flight.
module spi_rgb_led_mux_controller #(
	parameter int NUM_LEDS            = srlmc_pkg::NUM_LEDS_DEF,
	parameter int NUM_SENSOR_CHANNELS = srlmc_pkg::NUM_SENSOR_CHANNELS_DEF,
	parameter int QUEUE_DEPTH         = srlmc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	// item input
	input  logic       push,
	output logic       full,
	input  logic [1:0] opcode,
	input  logic [7:0] data_byte,
	input  logic [1:0] sensor_channel,
	input  logic [7:0] sensor_value,
	// result output
	output logic       empty,
	input  logic       pop,
	output logic       reply_valid,
	output logic [7:0] reply_byte,
	output logic [1:0] calibrate_request,
	output logic       scan_valid,
	output logic [2:0] led_select,
	output logic [7:0] red_duty,
	output logic [7:0] green_duty,
	output logic [7:0] blue_duty,
	output logic       red_on,
	output logic       green_on,
	output logic       blue_on,
	// scan_period register
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);

	srlmc_pkg::cmd_t cmd_in, cmd_head;
	srlmc_pkg::res_t res_new, res_head;
	logic            cmd_empty, cmd_pop;
	logic            res_full, res_push;

	// Classify the item on the way in.
	srlmc_front #(
		.NUM_SENSOR_CHANNELS(NUM_SENSOR_CHANNELS)
	) u_front (
		.opcode        (opcode),
		.data_byte     (data_byte),
		.sensor_channel(sensor_channel),
		.sensor_value  (sensor_value),
		.cmd           (cmd_in)
	);

	// Hold classified items until the back end can take them.
	srlmc_fifo #(
		.WIDTH($bits(srlmc_pkg::cmd_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (cmd_in),
		.full  (full),
		.pop   (cmd_pop),
		.rdata (cmd_head),
		.empty (cmd_empty)
	);

	// Execute commands against colour, sensor and scan state.
	srlmc_back #(
		.NUM_LEDS           (NUM_LEDS),
		.NUM_SENSOR_CHANNELS(NUM_SENSOR_CHANNELS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(!cmd_empty),
		.cmd      (cmd_head),
		.cmd_pop  (cmd_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res_new),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// Hold finished results until the consumer pops them.
	srlmc_fifo #(
		.WIDTH($bits(srlmc_pkg::res_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_new),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_head),
		.empty (empty)
	);

	assign reply_valid       = res_head.reply_valid;
	assign reply_byte        = res_head.reply_byte;
	assign calibrate_request = res_head.calibrate_request;
	assign scan_valid        = res_head.scan_valid;
	assign led_select        = res_head.led_select;
	assign red_duty          = res_head.red_duty;
	assign green_duty        = res_head.green_duty;
	assign blue_duty         = res_head.blue_duty;
	assign red_on            = res_head.red_on;
	assign green_on          = res_head.green_on;
	assign blue_on           = res_head.blue_on;

endmodule

// ===== hdl/srlmc_fifo.sv =====
// Small register queue used between the front, the back and the result port.
// Standalone; no package dependency.
module srlmc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [AW-1:0]    wptr_q, rptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = entry_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wptr_q] <= wdata;
		end
	end

endmodule

// ===== hdl/srlmc_front.sv =====
// Front end: classifies each incoming item into a command for the back end.
// Depends on srlmc_pkg.
module srlmc_front #(
	parameter int NUM_SENSOR_CHANNELS = srlmc_pkg::NUM_SENSOR_CHANNELS_DEF
) (
	input  logic [1:0]      opcode,
	input  logic [7:0]      data_byte,
	input  logic [1:0]      sensor_channel,
	input  logic [7:0]      sensor_value,
	output srlmc_pkg::cmd_t cmd
);

	always_comb begin
		cmd         = '0;
		cmd.data    = data_byte;
		cmd.channel = sensor_channel;
		cmd.value   = sensor_value;
		cmd.is_ff   = (data_byte == srlmc_pkg::CMD_FF);

		case (opcode)
			srlmc_pkg::OP_SPI:  cmd.kind = srlmc_pkg::K_SPI;
			srlmc_pkg::OP_TICK: cmd.kind = srlmc_pkg::K_TICK;
			srlmc_pkg::OP_SENSOR: begin
				// drop updates for channels that do not exist
				cmd.kind = (32'(sensor_channel) < NUM_SENSOR_CHANNELS) ?
					srlmc_pkg::K_SENSOR : srlmc_pkg::K_NOP;
			end
			default: cmd.kind = srlmc_pkg::K_NOP;
		endcase

		case (data_byte[7:4])
			srlmc_pkg::NIB_READ: begin
				if (32'(data_byte) < NUM_SENSOR_CHANNELS) begin
					cmd.spi_class = srlmc_pkg::SPI_READ;
				end else if (data_byte == srlmc_pkg::CMD_CAL) begin
					cmd.spi_class = srlmc_pkg::SPI_CAL;
				end else if (data_byte == srlmc_pkg::CMD_STORE) begin
					cmd.spi_class = srlmc_pkg::SPI_STORE;
				end else begin
					cmd.spi_class = srlmc_pkg::SPI_NONE;
				end
			end
			srlmc_pkg::NIB_SELECT: begin
				cmd.spi_class = data_byte[srlmc_pkg::LOAD_BIT] ?
					srlmc_pkg::SPI_LOAD : srlmc_pkg::SPI_CLEAR;
			end
			default: cmd.spi_class = srlmc_pkg::SPI_ZERO;
		endcase
	end

endmodule

// ===== hdl/srlmc_back.sv =====
// Back end: holds colour, sensor and scan state and executes classified commands.
// Depends on srlmc_pkg and the assertion macro header.
`include "spi_rgb_led_mux_controller_macros.svh"

module srlmc_back #(
	parameter int NUM_LEDS            = srlmc_pkg::NUM_LEDS_DEF,
	parameter int NUM_SENSOR_CHANNELS = srlmc_pkg::NUM_SENSOR_CHANNELS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	input  srlmc_pkg::cmd_t cmd,
	output logic            cmd_pop,
	input  logic            res_full,
	output logic            res_push,
	output srlmc_pkg::res_t res,
	input  logic            cfg_we,
	input  logic [7:0]      cfg_wdata
);
	localparam int LW  = $clog2(NUM_LEDS);
	localparam int SAW = (NUM_SENSOR_CHANNELS > 1) ? $clog2(NUM_SENSOR_CHANNELS) : 1;

	logic [23:0]            colour_q [NUM_LEDS];
	logic [7:0]             sensor_q [NUM_SENSOR_CHANNELS];
	logic [7:0]             scan_period_q;
	logic [7:0]             scan_wait_q;
	logic [LW-1:0]          scan_idx_q;
	logic [2:0]             target_q;
	srlmc_pkg::load_phase_t phase_q;

	logic                   exec;
	logic [LW-1:0]          scan_next;
	logic [23:0]            scan_col;
	logic [LW-1:0]          target_idx;
	logic                   target_ok;
	srlmc_pkg::load_phase_t phase_d;
	logic [2:0]             target_d;
	logic [7:0]             wait_d;
	logic [LW-1:0]          idx_d;
	logic                   col_we, col_clr, sens_we;

	assign exec     = cmd_valid && !res_full;
	assign cmd_pop  = exec;
	assign res_push = exec;

	assign scan_next  = (scan_idx_q == LW'(NUM_LEDS - 1)) ? '0 : scan_idx_q + 1'b1;
	assign scan_col   = colour_q[scan_next];
	assign target_idx = LW'(target_q);
	assign target_ok  = (32'(target_q) < NUM_LEDS);

	always_comb begin
		res      = '0;
		phase_d  = phase_q;
		target_d = target_q;
		wait_d   = scan_wait_q;
		idx_d    = scan_idx_q;
		col_we   = 1'b0;
		col_clr  = 1'b0;
		sens_we  = 1'b0;

		case (cmd.kind)
			srlmc_pkg::K_SPI: begin
				if (cmd.is_ff) begin
					res.reply_valid = 1'b1;
				end
				if (phase_q != srlmc_pkg::PH_IDLE) begin
					col_we = target_ok;
					case (phase_q)
						srlmc_pkg::PH_RED:   phase_d = srlmc_pkg::PH_GREEN;
						srlmc_pkg::PH_GREEN: phase_d = srlmc_pkg::PH_BLUE;
						default:             phase_d = srlmc_pkg::PH_IDLE;
					endcase
				end else begin
					case (cmd.spi_class)
						srlmc_pkg::SPI_READ: begin
							res.reply_valid = 1'b1;
							res.reply_byte  = sensor_q[SAW'(cmd.data)];
						end
						srlmc_pkg::SPI_CAL:   res.calibrate_request = srlmc_pkg::CAL_ONLY;
						srlmc_pkg::SPI_STORE: res.calibrate_request = srlmc_pkg::CAL_STORE;
						srlmc_pkg::SPI_LOAD: begin
							target_d = cmd.data[2:0];
							phase_d  = srlmc_pkg::PH_RED;
						end
						srlmc_pkg::SPI_CLEAR: begin
							target_d = cmd.data[2:0];
							col_clr  = (32'(cmd.data[2:0]) < NUM_LEDS);
						end
						srlmc_pkg::SPI_ZERO:  res.reply_valid = 1'b1;
						default: ;
					endcase
				end
			end
			srlmc_pkg::K_TICK: begin
				if (scan_wait_q < scan_period_q) begin
					wait_d = scan_wait_q + 1'b1;
				end else begin
					wait_d           = '0;
					idx_d            = scan_next;
					res.scan_valid   = 1'b1;
					res.led_select   = 3'(scan_next);
					res.red_duty     = scan_col[23:16];
					res.green_duty   = scan_col[15:8];
					res.blue_duty    = scan_col[7:0];
					res.red_on       = |scan_col[23:16];
					res.green_on     = |scan_col[15:8];
					res.blue_on      = |scan_col[7:0];
				end
			end
			srlmc_pkg::K_SENSOR: sens_we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEDS; i++) begin
				colour_q[i] <= srlmc_pkg::start_colour(i);
			end
			for (int i = 0; i < NUM_SENSOR_CHANNELS; i++) begin
				sensor_q[i] <= '0;
			end
			scan_period_q <= srlmc_pkg::SCAN_PERIOD_RESET;
			scan_wait_q   <= '0;
			scan_idx_q    <= '0;
			target_q      <= '0;
			phase_q       <= srlmc_pkg::PH_IDLE;
		end else begin
			if (cfg_we) begin
				scan_period_q <= cfg_wdata;
			end
			if (exec) begin
				phase_q     <= phase_d;
				target_q    <= target_d;
				scan_wait_q <= wait_d;
				scan_idx_q  <= idx_d;
				if (sens_we) begin
					sensor_q[SAW'(cmd.channel)] <= cmd.value;
				end
				if (col_clr) begin
					colour_q[LW'(cmd.data[2:0])] <= '0;
				end
				if (col_we) begin
					case (phase_q)
						srlmc_pkg::PH_RED:   colour_q[target_idx][23:16] <= {3'b000, cmd.data[4:0]};
						srlmc_pkg::PH_GREEN: colour_q[target_idx][15:8]  <= {3'b000, cmd.data[4:0]};
						default:             colour_q[target_idx][7:0]   <= {3'b000, cmd.data[4:0]};
					endcase
				end
			end
		end
	end

	`SRLMC_ASSERT_NOW(a_one_kind, clk, arst_n, res_push, !(res.reply_valid && res.scan_valid))
	`SRLMC_ASSERT_NEXT(a_load_start, clk, arst_n, exec && cmd.kind == srlmc_pkg::K_SPI && phase_q == srlmc_pkg::PH_IDLE && cmd.spi_class == srlmc_pkg::SPI_LOAD, phase_q == srlmc_pkg::PH_RED)
	`SRLMC_ASSERT_NEXT(a_blue_done, clk, arst_n, exec && cmd.kind == srlmc_pkg::K_SPI && phase_q == srlmc_pkg::PH_BLUE, phase_q == srlmc_pkg::PH_IDLE)
	`SRLMC_ASSERT_NEXT(a_scan_rearm, clk, arst_n, exec && res.scan_valid, scan_wait_q == '0)

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for spi_rgb_led_mux_controller: queue-style item and
// result handshakes, a cycle-free behavioural predictor and field-by-field checks.
// Depends on srlmc_pkg and the RTL of the block; nothing else.
`timescale 1ns / 100ps

module tb;

	localparam int N_LED        = srlmc_pkg::NUM_LEDS_DEF;
	localparam int N_SENS       = srlmc_pkg::NUM_SENSOR_CHANNELS_DEF;
	localparam int IDLE_PCT     = 29;    // chance of a gap per cycle, each side
	localparam int QUIET_CYCLES = 4;     // idle cycles before a register write
	localparam int STALL_LIMIT  = 2000;  // cycles with no handshake at all
	localparam int CALM_FROM    = 400;   // items in this window run without gaps
	localparam int CALM_TO      = 700;

	// One input item as it sits on the ports.
	typedef struct packed {
		srlmc_pkg::cmd_kind_t kind;
		logic [7:0]           data;
		logic [1:0]           ch;
		logic [7:0]           val;
	} item_t;

	// What the driver works through: items, register writes and drain points.
	typedef enum logic [1:0] {
		E_ITEM  = 2'd0,
		E_CFG   = 2'd1,
		E_DRAIN = 2'd2
	} entry_tag_t;

	typedef struct {
		entry_tag_t tag;
		item_t      it;
		logic [7:0] cfg;
	} entry_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [1:0] opcode = srlmc_pkg::OP_SPI;
	logic [7:0] data_byte = 8'h00;
	logic [1:0] sensor_channel = 2'd0;
	logic [7:0] sensor_value = 8'h00;
	logic       empty;
	logic       pop = 1'b0;
	logic       reply_valid;
	logic [7:0] reply_byte;
	logic [1:0] calibrate_request;
	logic       scan_valid;
	logic [2:0] led_select;
	logic [7:0] red_duty;
	logic [7:0] green_duty;
	logic [7:0] blue_duty;
	logic       red_on;
	logic       green_on;
	logic       blue_on;
	logic       cfg_we = 1'b0;
	logic [7:0] cfg_wdata = 8'h00;

	// Shadow of the block's state, advanced once per accepted item.
	logic [7:0]             led_rgb [N_LED][3];
	logic [7:0]             sensor_rd [N_SENS];
	logic [2:0]             sel_led;
	srlmc_pkg::load_phase_t load_ph;
	int                     scan_idx;
	logic [7:0]             scan_wait;
	logic [7:0]             scan_period_m;

	entry_t          pending_q [$];   // stimulus still to be offered
	srlmc_pkg::res_t result_q [$];    // predicted results, oldest first
	item_t           cur_item;        // item now on the input ports
	int unsigned     n_in = 0;        // items accepted
	int unsigned     n_out = 0;       // results accepted
	int unsigned     idle_run = 0;    // consecutive cycles with nothing in flight
	int unsigned     stall_cnt = 0;
	int unsigned     n_err = 0;
	logic            calm;

	assign calm = (n_in >= CALM_FROM) && (n_in < CALM_TO);

	spi_rgb_led_mux_controller DUT (
		.clk               (clk),
		.arst_n            (arst_n),
		.push              (push),
		.full              (full),
		.opcode            (opcode),
		.data_byte         (data_byte),
		.sensor_channel    (sensor_channel),
		.sensor_value      (sensor_value),
		.empty             (empty),
		.pop               (pop),
		.reply_valid       (reply_valid),
		.reply_byte        (reply_byte),
		.calibrate_request (calibrate_request),
		.scan_valid        (scan_valid),
		.led_select        (led_select),
		.red_duty          (red_duty),
		.green_duty        (green_duty),
		.blue_duty         (blue_duty),
		.red_on            (red_on),
		.green_on          (green_on),
		.blue_on           (blue_on),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata)
	);

	// Work out the result of one item and advance the shadow state.
	function automatic srlmc_pkg::res_t predict_result(input item_t it);
		srlmc_pkg::res_t r;
		int              c;
		r = '0;
		case (it.kind)
			srlmc_pkg::K_SPI: begin
				// An all-ones byte always answers zero, even mid-load.
				if (it.data == srlmc_pkg::CMD_FF)
					r.reply_valid = 1'b1;
				if (load_ph != srlmc_pkg::PH_IDLE) begin
					// Colour load: keep the low five bits, step red, green, blue.
					case (load_ph)
						srlmc_pkg::PH_RED:   c = 0;
						srlmc_pkg::PH_GREEN: c = 1;
						default:             c = 2;
					endcase
					if (sel_led < N_LED)
						led_rgb[sel_led][c] = {3'b000, it.data[4:0]};
					case (load_ph)
						srlmc_pkg::PH_RED:   load_ph = srlmc_pkg::PH_GREEN;
						srlmc_pkg::PH_GREEN: load_ph = srlmc_pkg::PH_BLUE;
						default:             load_ph = srlmc_pkg::PH_IDLE;
					endcase
				end else begin
					case (it.data[7:4])
						srlmc_pkg::NIB_READ: begin
							if (it.data < N_SENS) begin
								r.reply_valid = 1'b1;
								r.reply_byte  = sensor_rd[it.data[1:0]];
							end else if (it.data == srlmc_pkg::CMD_CAL) begin
								r.calibrate_request = srlmc_pkg::CAL_ONLY;
							end else if (it.data == srlmc_pkg::CMD_STORE) begin
								r.calibrate_request = srlmc_pkg::CAL_STORE;
							end
						end
						srlmc_pkg::NIB_SELECT: begin
							sel_led = it.data[2:0];
							if (it.data[srlmc_pkg::LOAD_BIT])
								load_ph = srlmc_pkg::PH_RED;
							else if (sel_led < N_LED)
								for (c = 0; c < 3; c++)
									led_rgb[sel_led][c] = 8'h00;
						end
						default: r.reply_valid = 1'b1;
					endcase
				end
			end
			srlmc_pkg::K_TICK: begin
				if (scan_wait < scan_period_m) begin
					scan_wait = scan_wait + 8'd1;
				end else begin
					scan_idx     = (scan_idx + 1 >= N_LED) ? 0 : scan_idx + 1;
					r.scan_valid = 1'b1;
					r.led_select = scan_idx[2:0];
					r.red_duty   = led_rgb[scan_idx][0];
					r.green_duty = led_rgb[scan_idx][1];
					r.blue_duty  = led_rgb[scan_idx][2];
					r.red_on     = (r.red_duty != 8'h00);
					r.green_on   = (r.green_duty != 8'h00);
					r.blue_on    = (r.blue_duty != 8'h00);
					scan_wait    = 8'h00;
				end
			end
			srlmc_pkg::K_SENSOR: begin
				if (it.ch < N_SENS)
					sensor_rd[it.ch] = it.val;
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic queue_item(input srlmc_pkg::cmd_kind_t k, input logic [7:0] d,
	                          input logic [1:0] ch, input logic [7:0] v);
		entry_t e;
		e.tag     = E_ITEM;
		e.it.kind = k;
		e.it.data = d;
		e.it.ch   = ch;
		e.it.val  = v;
		e.cfg     = 8'h00;
		pending_q.push_back(e);
	endtask

	task automatic queue_ctrl(input entry_tag_t tag, input logic [7:0] v);
		entry_t e;
		e.tag = tag;
		e.it  = '0;
		e.cfg = v;
		pending_q.push_back(e);
	endtask

	// Random traffic: mostly well-formed colour loads, reads and ticks, with
	// noise bytes, cut-short loads and the odd drain point mixed in.
	task automatic queue_random(input int n_items, input int tick_pct);
		int         added;
		int         roll;
		int         k;
		int         j;
		logic [2:0] led;
		logic [1:0] chn;
		added = 0;
		while (added < n_items) begin
			if ($urandom_range(199) == 0)
				queue_ctrl(E_DRAIN, 8'h00);
			led  = 3'($urandom_range(7));
			chn  = 2'($urandom_range(3));
			roll = $urandom_range(99);
			if (roll < tick_pct) begin
				queue_item(srlmc_pkg::K_TICK, 8'($urandom_range(255)),
				           2'($urandom_range(3)), 8'($urandom_range(255)));
				added++;
			end else begin
				roll = $urandom_range(99);
				if (roll < 30) begin
					queue_item(srlmc_pkg::K_SPI, {srlmc_pkg::NIB_SELECT, 1'b1, led},
					           2'($urandom_range(3)), 8'($urandom_range(255)));
					// Now and then cut the load short so a later byte lands in it.
					k = ($urandom_range(9) == 0) ? $urandom_range(2) : 3;
					for (j = 0; j < k; j++)
						queue_item(srlmc_pkg::K_SPI, 8'($urandom_range(255)),
						           2'($urandom_range(3)), 8'($urandom_range(255)));
					added += k + 1;
				end else begin
					if (roll < 45)
						queue_item(srlmc_pkg::K_SPI, {srlmc_pkg::NIB_READ, 2'b00, chn},
						           2'($urandom_range(3)), 8'($urandom_range(255)));
					else if (roll < 52)
						queue_item(srlmc_pkg::K_SPI,
						           roll[0] ? srlmc_pkg::CMD_CAL : srlmc_pkg::CMD_STORE,
						           2'($urandom_range(3)), 8'($urandom_range(255)));
					else if (roll < 62)
						queue_item(srlmc_pkg::K_SPI, {srlmc_pkg::NIB_SELECT, 1'b0, led},
						           2'($urandom_range(3)), 8'($urandom_range(255)));
					else if (roll < 77)
						queue_item(srlmc_pkg::K_SENSOR, 8'($urandom_range(255)), chn,
						           8'($urandom_range(255)));
					else if (roll < 82)
						queue_item(srlmc_pkg::K_NOP, 8'($urandom_range(255)),
						           2'($urandom_range(3)), 8'($urandom_range(255)));
					else if (roll < 86)
						queue_item(srlmc_pkg::K_SPI, srlmc_pkg::CMD_FF,
						           2'($urandom_range(3)), 8'($urandom_range(255)));
					else
						queue_item(srlmc_pkg::K_SPI, 8'($urandom_range(255)),
						           2'($urandom_range(3)), 8'($urandom_range(255)));
					added++;
				end
			end
		end
	endtask

	task automatic check_field(input string name, input logic [7:0] want,
	                           input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%02h, got 0x%02h", name, want, got);
			n_err++;
		end
	endtask

	initial begin
		forever #2 clk = ~clk;
	end

	// Driver: offer items from the pending queue, predict each one as it is
	// accepted, and write the register only once nothing is in flight.
	always @(posedge clk) begin : item_drv
		entry_t head;
		logic   push_nx;
		logic   we_nx;
		if (!arst_n) begin
			idle_run = 0;
		end else begin
			if (push && !full) begin
				result_q.push_back(predict_result(cur_item));
				n_in <= n_in + 1;
			end
			// The write lands at this edge; items after it see the new period.
			if (cfg_we)
				scan_period_m = cfg_wdata;
			if (!push && !cfg_we && n_in == n_out)
				idle_run++;
			else
				idle_run = 0;

			push_nx = 1'b0;
			we_nx   = 1'b0;
			if (push && full) begin
				// Hold the item until the block takes it.
				push_nx = 1'b1;
			end else if (pending_q.size() != 0) begin
				head = pending_q[0];
				if (head.tag == E_ITEM) begin
					if (calm || $urandom_range(99) >= IDLE_PCT) begin
						push_nx        = 1'b1;
						opcode         <= head.it.kind;
						data_byte      <= head.it.data;
						sensor_channel <= head.it.ch;
						sensor_value   <= head.it.val;
						cur_item       = head.it;
						void'(pending_q.pop_front());
					end
				end else if (idle_run >= QUIET_CYCLES) begin
					// Drained: perform the write, or simply move past the drain point.
					if (head.tag == E_CFG) begin
						we_nx     = 1'b1;
						cfg_wdata <= head.cfg;
					end
					void'(pending_q.pop_front());
				end
			end
			push   <= push_nx;
			cfg_we <= we_nx;
		end
	end

	// Monitor: take results with random back-pressure and compare each against
	// the oldest prediction.
	always @(posedge clk) begin : result_mon
		srlmc_pkg::res_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				n_out <= n_out + 1;
				if (result_q.size() == 0) begin
					$error("result item arrived with nothing expected");
					n_err++;
				end else begin
					want = result_q.pop_front();
					check_field("reply_valid", 8'(want.reply_valid), 8'(reply_valid));
					check_field("reply_byte", want.reply_byte, reply_byte);
					check_field("calibrate_request", 8'(want.calibrate_request),
					            8'(calibrate_request));
					check_field("scan_valid", 8'(want.scan_valid), 8'(scan_valid));
					check_field("led_select", 8'(want.led_select), 8'(led_select));
					check_field("red_duty", want.red_duty, red_duty);
					check_field("green_duty", want.green_duty, green_duty);
					check_field("blue_duty", want.blue_duty, blue_duty);
					check_field("red_on", 8'(want.red_on), 8'(red_on));
					check_field("green_on", 8'(want.green_on), 8'(green_on));
					check_field("blue_on", 8'(want.blue_on), 8'(blue_on));
				end
			end
			pop <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Watchdog: end the run if neither side moves an item for too long.
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			stall_cnt <= 0;
		end else if (stall_cnt >= STALL_LIMIT) begin
			$display("** spi_rgb_led_mux_controller: FAILED **");
			$finish;
		end else begin
			stall_cnt <= stall_cnt + 1;
		end
	end

	initial begin : stimulus
		logic [23:0] boot_rgb [6];
		logic [23:0] v;
		int          i;
		int          c;

		// Shadow state after reset: the six-colour start pattern, rest off.
		boot_rgb = '{24'hff0000, 24'h00ff00, 24'h0000ff, 24'hffff00, 24'hff00ff,
		             24'h00ffff};
		for (i = 0; i < N_LED; i++) begin
			v = (i < 6) ? boot_rgb[i] : 24'h000000;
			for (c = 0; c < 3; c++)
				led_rgb[i][c] = v[23 - 8 * c -: 8];
		end
		for (i = 0; i < N_SENS; i++)
			sensor_rd[i] = 8'h00;
		sel_led       = 3'd0;
		load_ph       = srlmc_pkg::PH_IDLE;
		scan_idx      = 0;
		scan_wait     = 8'h00;
		scan_period_m = srlmc_pkg::SCAN_PERIOD_RESET;

		// Directed part at the reset period: sensor extremes and read-back,
		// both calibrate requests, a silent low byte, a colour load with an
		// all-ones byte inside it, clears, zero replies, the unused opcode and
		// ticks that only wait.
		queue_item(srlmc_pkg::K_SENSOR, 8'h00, 2'd0, 8'hff);
		queue_item(srlmc_pkg::K_SENSOR, 8'hff, 2'd1, 8'h00);
		queue_item(srlmc_pkg::K_SENSOR, 8'h00, 2'd2, 8'ha5);
		queue_item(srlmc_pkg::K_SENSOR, 8'hff, 2'd3, 8'h5a);
		for (i = 0; i < N_SENS; i++)
			queue_item(srlmc_pkg::K_SPI, {srlmc_pkg::NIB_READ, 4'(i)}, 2'd0, 8'h00);
		queue_item(srlmc_pkg::K_SPI, srlmc_pkg::CMD_CAL, 2'd3, 8'hff);
		queue_item(srlmc_pkg::K_SPI, srlmc_pkg::CMD_STORE, 2'd0, 8'h00);
		queue_item(srlmc_pkg::K_SPI, 8'h07, 2'd0, 8'h00);
		queue_item(srlmc_pkg::K_SPI, {srlmc_pkg::NIB_SELECT, 4'b1011}, 2'd0, 8'h00);
		queue_item(srlmc_pkg::K_SPI, srlmc_pkg::CMD_FF, 2'd0, 8'h00);
		queue_item(srlmc_pkg::K_SPI, 8'h00, 2'd0, 8'h00);
		queue_item(srlmc_pkg::K_SPI, 8'h15, 2'd0, 8'h00);
		queue_item(srlmc_pkg::K_SPI, {srlmc_pkg::NIB_SELECT, 4'b0000}, 2'd0, 8'h00);
		queue_item(srlmc_pkg::K_SPI, {srlmc_pkg::NIB_SELECT, 4'b0111}, 2'd0, 8'h00);
		queue_item(srlmc_pkg::K_SPI, srlmc_pkg::CMD_FF, 2'd0, 8'h00);
		queue_item(srlmc_pkg::K_SPI, 8'h20, 2'd0, 8'h00);
		queue_item(srlmc_pkg::K_SPI, 8'h80, 2'd0, 8'h00);
		queue_item(srlmc_pkg::K_NOP, 8'hff, 2'd3, 8'hff);
		for (i = 0; i < 3; i++)
			queue_item(srlmc_pkg::K_TICK, 8'h00, 2'd0, 8'h00);

		// Random phases at several scan periods, extremes first; each write
		// waits until every earlier result has been taken.
		queue_ctrl(E_CFG, 8'h00);
		queue_random(200, 35);
		queue_ctrl(E_CFG, 8'hff);
		queue_random(300, 90);
		queue_ctrl(E_CFG, 8'h01);
		queue_random(175, 40);
		queue_ctrl(E_CFG, 8'($urandom_range(9, 2)));
		queue_random(175, 40);
		queue_ctrl(E_CFG, 8'($urandom_range(255)));
		queue_random(175, 40);
		queue_ctrl(E_CFG, 8'h00);
		queue_random(175, 30);

		// Hold reset, then release it at an edge.
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for the last item to go in and its result to come out.
		@(negedge clk);
		while (pending_q.size() != 0 || push || n_in != n_out)
			@(negedge clk);
		repeat (8) @(negedge clk);

		if (result_q.size() != 0) begin
			$error("%0d expected result items never arrived", result_q.size());
			n_err++;
		end
		if (n_err == 0)
			$display("** spi_rgb_led_mux_controller: PASSED **");
		else
			$display("** spi_rgb_led_mux_controller: FAILED **");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/srlmc_pkg.sv
hdl/srlmc_fifo.sv
hdl/srlmc_front.sv
hdl/srlmc_back.sv
hdl/spi_rgb_led_mux_controller.sv
verif/tb.sv
